// File: rtl/core/box_blur_3x3_edge_adaptive_top_assert.svh
// Assertion macros for the 3x3 box blur block.
// Included by the top-level RTL file, which carries the concurrent checks; depends on nothing.
`ifndef BOX_BLUR_3X3_EDGE_ADAPTIVE_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_ADAPTIVE_TOP_ASSERT_SVH

// Plain property, checked while out of reset.
`define BB3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication, checked while out of reset.
`define BB3_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BB3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur.
// No dependencies; used by every module of the block.
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SH   = 18;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef struct packed {
    logic [2:0] row_mask;
    logic [2:0] col_mask;
  } sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
  } sums_t;

  typedef struct packed {
    sums_t            sums;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
  } issue_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_GEN
  } fsm_e;

  function automatic logic [1:0] ones3(logic [2:0] m);
    return 2'(m[0]) + 2'(m[1]) + 2'(m[2]);
  endfunction

  function automatic logic [CNT_W-1:0] cell_count(sel_t s);
    return CNT_W'(ones3(s.row_mask)) * CNT_W'(ones3(s.col_mask));
  endfunction

  // ceil(2^18 / (2n)); exact quotient for every dividend below 2^13
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bb3_linebuf.sv
// Line buffer: one synchronous memory holding the two previous rows per column.
// Depends on bb3_pkg for the entry type.
`default_nettype none

module bb3_linebuf #(
  parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(bb3_pkg::MAX_WIDTH_DEF)
) (
  input  wire logic            clk_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output bb3_pkg::line_t       rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire bb3_pkg::line_t  wr_data_i
);

  bb3_pkg::line_t mem_q [DEPTH];
  bb3_pkg::line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/bb3_window.sv
// 3x3 pixel window with masked per-channel sums over the clipped neighborhood.
// Depends on bb3_pkg for pixel, select and sum types.
`default_nettype none

module bb3_window (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire bb3_pkg::pix_t top_i,
  input  wire bb3_pkg::pix_t mid_i,
  input  wire bb3_pkg::pix_t bot_i,
  input  wire bb3_pkg::sel_t sel_i,
  output bb3_pkg::sums_t     sums_o
);

  bb3_pkg::pix_t win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          win_q[k][m] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= top_i;
      win_q[1][2] <= mid_i;
      win_q[2][2] <= bot_i;
    end
  end

  always_comb begin
    sums_o = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (sel_i.row_mask[k] && sel_i.col_mask[m]) begin
          sums_o.sum_red   = sums_o.sum_red   + bb3_pkg::SUM_W'(win_q[k][m].red);
          sums_o.sum_green = sums_o.sum_green + bb3_pkg::SUM_W'(win_q[k][m].green);
          sums_o.sum_blue  = sums_o.sum_blue  + bb3_pkg::SUM_W'(win_q[k][m].blue);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bb3_mean.sv
// Two-stage result pipeline: registered sums, then reciprocal multiply into the
// output register. Depends on bb3_pkg for issue and result types.
`default_nettype none

module bb3_mean (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            iss_valid_i,
  output logic                 iss_ready_o,
  input  wire bb3_pkg::issue_t iss_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output bb3_pkg::out_beat_t   out_data_o
);

  localparam int X_W = bb3_pkg::SUM_W + 1;
  localparam int P_W = X_W + bb3_pkg::RECIP_W;

  function automatic logic [7:0] mean8(logic [bb3_pkg::SUM_W-1:0] s,
                                       logic [bb3_pkg::CNT_W-1:0] n);
    logic [X_W-1:0] x;
    logic [P_W-1:0] p;
    x = {s, 1'b0} + X_W'(n);
    p = P_W'(x) * P_W'(bb3_pkg::recip(n));
    return p[bb3_pkg::RECIP_SH +: 8];
  endfunction

  logic               s1_valid_q, s1_valid_d;
  bb3_pkg::issue_t    s1_q;
  logic               out_valid_q, out_valid_d;
  bb3_pkg::out_beat_t out_q, out_d;
  logic               out_free, s1_adv, s1_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign iss_ready_o = !s1_valid_q || out_free;
  assign s1_load     = iss_valid_i && iss_ready_o;

  always_comb begin
    s1_valid_d  = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
    out_d.out_red   = mean8(s1_q.sums.sum_red,   s1_q.cnt);
    out_d.out_green = mean8(s1_q.sums.sum_green, s1_q.cnt);
    out_d.out_blue  = mean8(s1_q.sums.sum_blue,  s1_q.cnt);
    out_d.out_row   = s1_q.out_row;
    out_d.out_col   = s1_q.out_col;
    out_d.run_last  = s1_q.run_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= iss_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/box_blur_3x3_edge_adaptive_top.sv
// Top level of the streaming 3x3 box blur: sequencer, counters and config.
// Depends on bb3_pkg, bb3_linebuf, bb3_window, bb3_mean and the assert header.
//
// Usage: RGB pixels enter in raster order on in_data_i (valid/stall). Each
// accepted pixel completes zero to four blurred pixels, which leave on
// out_data_o (valid/stall) in raster order with their row and column; the
// last one caused by a pixel carries run_last. frame_width and frame_height
// are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle;
// any write restarts the frame at row 0, column 0.
// Sequence: a pixel is handled as a line buffer read, then window update and
// write-back on the same memory entry, then its results, issued one per cycle
// into the sum/divide pipeline while that pipeline is not stalled. Each
// result is registered in the sum stage and then in the output register.
// Reset: counters clear, width 640, height 480, window zero. The line buffer
// is not cleared; border clipping keeps unwritten entries out of results.
// Stall: a stalled result holds in the output register, one more result waits
// in the sum stage, then issue pauses and in_stall_o stays high until the
// current pixel's results are all issued.
`default_nettype none
`include "box_blur_3x3_edge_adaptive_top_assert.svh"

module box_blur_3x3_edge_adaptive_top #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire bb3_pkg::in_beat_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bb3_pkg::out_beat_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WCMP  = (CW + 1 > bb3_pkg::FW_W) ? CW + 1 : bb3_pkg::FW_W;
  localparam int HCMP  = (RW + 1 > bb3_pkg::FH_W) ? RW + 1 : bb3_pkg::FH_W;

  localparam logic [1:0] KIND_PREV_PREV = 2'd0;
  localparam logic [1:0] KIND_PREV_CUR  = 2'd1;
  localparam logic [1:0] KIND_CUR_PREV  = 2'd2;
  localparam logic [1:0] KIND_CUR_CUR   = 2'd3;

  bb3_pkg::fsm_e state_q, state_d;

  logic [bb3_pkg::FW_W-1:0] frame_width_q, frame_width_d;
  logic [bb3_pkg::FH_W-1:0] frame_height_q, frame_height_d;
  logic [CW-1:0]            col_q, col_d, cur_col_q;
  logic [RW-1:0]            row_q, row_d, cur_row_q;
  logic [3:0]               pend_q, pend_d, pend_new;
  bb3_pkg::pix_t            pix_q;

  logic [WCMP-1:0] fw_ext;
  logic [HCMP-1:0] fh_ext;
  logic [CW-1:0]   wlast;
  logic [RW-1:0]   hlast;

  logic            in_fire, rd_en, wr_en, shift, iss_valid, iss_ready, gen_fire;
  bb3_pkg::line_t  rd_data, wr_data;
  bb3_pkg::sel_t   sel;
  bb3_pkg::sums_t  sums;
  bb3_pkg::issue_t iss;

  logic [1:0]       kind;
  logic [3:0]       kind_hot;
  logic             prev_row, prev_col, kind_last;
  logic [RW-1:0]    res_row;
  logic [CW-1:0]    res_col;

  // Effective frame limits
  always_comb begin
    fw_ext = WCMP'(frame_width_q);
    fh_ext = HCMP'(frame_height_q);
    if (fw_ext == '0) begin
      wlast = '0;
    end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(fw_ext - WCMP'(1));
    end
    if (fh_ext == '0) begin
      hlast = '0;
    end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
      hlast = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast = RW'(fh_ext - HCMP'(1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bb3_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bb3_pkg::ST_UPD;
        end
      end
      bb3_pkg::ST_UPD: begin
        state_d = (pend_new != '0) ? bb3_pkg::ST_GEN : bb3_pkg::ST_IDLE;
      end
      bb3_pkg::ST_GEN: begin
        if (gen_fire && kind_last) begin
          state_d = bb3_pkg::ST_IDLE;
        end
      end
      default: state_d = bb3_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    shift      = 1'b0;
    iss_valid  = 1'b0;
    case (state_q)
      bb3_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      bb3_pkg::ST_UPD: begin
        wr_en = 1'b1;
        shift = 1'b1;
      end
      bb3_pkg::ST_GEN: begin
        iss_valid = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_fire  = in_valid_i && !in_stall_o;
  assign gen_fire = iss_valid && iss_ready;

  // Results completed by the pixel at (row_q, col_q)
  always_comb begin
    pend_new[KIND_PREV_PREV] = (row_q != '0) && (col_q != '0);
    pend_new[KIND_PREV_CUR]  = (row_q != '0) && (col_q == wlast);
    pend_new[KIND_CUR_PREV]  = (row_q == hlast) && (col_q != '0);
    pend_new[KIND_CUR_CUR]   = (row_q == hlast) && (col_q == wlast);
  end

  // Pick the next pending result in raster order
  always_comb begin
    if (pend_q[KIND_PREV_PREV]) begin
      kind = KIND_PREV_PREV;
    end else if (pend_q[KIND_PREV_CUR]) begin
      kind = KIND_PREV_CUR;
    end else if (pend_q[KIND_CUR_PREV]) begin
      kind = KIND_CUR_PREV;
    end else begin
      kind = KIND_CUR_CUR;
    end
    kind_hot  = 4'b0001 << kind;
    kind_last = (pend_q & ~kind_hot) == '0;
    prev_row  = !kind[1];
    prev_col  = !kind[0];
    if (prev_row) begin
      sel.row_mask = {1'b1, 1'b1, cur_row_q > RW'(1)};
      res_row      = cur_row_q - RW'(1);
    end else begin
      sel.row_mask = {1'b1, cur_row_q != '0, 1'b0};
      res_row      = cur_row_q;
    end
    if (prev_col) begin
      sel.col_mask = {1'b1, 1'b1, cur_col_q > CW'(1)};
      res_col      = cur_col_q - CW'(1);
    end else begin
      sel.col_mask = {1'b1, cur_col_q != '0, 1'b0};
      res_col      = cur_col_q;
    end
    iss.sums     = sums;
    iss.cnt      = bb3_pkg::cell_count(sel);
    iss.out_row  = bb3_pkg::ROW_W'(res_row);
    iss.out_col  = bb3_pkg::COL_W'(res_col);
    iss.run_last = kind_last;
  end

  // Counters, pending set and configuration
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    col_d          = col_q;
    row_d          = row_q;
    pend_d         = pend_q;
    if (state_q == bb3_pkg::ST_UPD) begin
      pend_d = pend_new;
      if (col_q == wlast) begin
        col_d = '0;
        row_d = (row_q == hlast) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (gen_fire) begin
      pend_d = pend_q & ~kind_hot;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_d  = cfg_wdata_i[bb3_pkg::FW_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_d = cfg_wdata_i;
        default:                   frame_height_d = frame_height_q;
      endcase
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bb3_pkg::ST_IDLE;
      frame_width_q  <= bb3_pkg::FW_RESET;
      frame_height_q <= bb3_pkg::FH_RESET;
      col_q          <= '0;
      row_q          <= '0;
      pend_q         <= '0;
    end else begin
      state_q        <= state_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      col_q          <= col_d;
      row_q          <= row_d;
      pend_q         <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= '{red: in_data_i.in_red, green: in_data_i.in_green, blue: in_data_i.in_blue};
    end
    if (state_q == bb3_pkg::ST_UPD) begin
      cur_col_q <= col_q;
      cur_row_q <= row_q;
    end
  end

  assign wr_data = '{older: rd_data.newer, newer: pix_q};

  bb3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (col_q),
    .wr_data_i (wr_data)
  );

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (shift),
    .top_i   (rd_data.older),
    .mid_i   (rd_data.newer),
    .bot_i   (pix_q),
    .sel_i   (sel),
    .sums_o  (sums)
  );

  bb3_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_valid_i (iss_valid),
    .iss_ready_o (iss_ready),
    .iss_i       (iss),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `BB3_ASSERT(a_col_in_frame, clk_i, rst_ni, col_q <= wlast, "column counter past row end")
  `BB3_ASSERT(a_row_in_frame, clk_i, rst_ni, row_q <= hlast, "row counter past frame end")
  `BB3_ASSERT_IMPLY(a_gen_has_work, clk_i, rst_ni, state_q == bb3_pkg::ST_GEN, pend_q != '0, "issue state with nothing pending")
  `BB3_ASSERT_NEXT(a_accept_then_update, clk_i, rst_ni, in_fire, state_q == bb3_pkg::ST_UPD, "accepted beat not followed by update")
  `BB3_ASSERT_NEXT(a_last_ends_item, clk_i, rst_ni, gen_fire && iss.run_last, state_q == bb3_pkg::ST_IDLE, "last result issued but sequencer still busy")

endmodule

`default_nettype wire

// File: sim/tb_box_blur_3x3_edge_adaptive_top.sv
`timescale 1ns / 1ps
// Testbench for box_blur_3x3_edge_adaptive_top: directed and random RGB streams
// over many frame sizes, each blurred beat checked against a clipped 3x3 mean.
// Depends on bb3_pkg and the block's RTL; self-contained otherwise.

module tb_box_blur_3x3_edge_adaptive_top;

  class blur_checker;
    bb3_pkg::pix_t older_line[bb3_pkg::MAX_WIDTH_DEF];
    bb3_pkg::pix_t newer_line[bb3_pkg::MAX_WIDTH_DEF];
    bb3_pkg::pix_t win[9];
    int row_pos;
    int col_pos;
    logic [bb3_pkg::FW_W-1:0] width_reg;
    logic [bb3_pkg::FH_W-1:0] height_reg;
    bb3_pkg::out_beat_t blurred_due[$];
    int mismatches;

    function new();
      foreach (older_line[x]) begin
        older_line[x] = '0;
        newer_line[x] = '0;
      end
      foreach (win[x]) win[x] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = bb3_pkg::FW_RESET;
      height_reg = bb3_pkg::FH_RESET;
      mismatches = 0;
    endfunction

    function int frame_w();
      if (width_reg == 0) return 1;
      if (width_reg > bb3_pkg::MAX_WIDTH_DEF) return bb3_pkg::MAX_WIDTH_DEF;
      return int'(width_reg);
    endfunction

    function int frame_h();
      if (height_reg == 0) return 1;
      if (height_reg > bb3_pkg::MAX_HEIGHT_DEF) return bb3_pkg::MAX_HEIGHT_DEF;
      return int'(height_reg);
    endfunction

    function void write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                            logic [bb3_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bb3_pkg::REG_FRAME_WIDTH:  width_reg = val[bb3_pkg::FW_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: height_reg = val[bb3_pkg::FH_W-1:0];
        default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function bb3_pkg::out_beat_t blurred(int r, int c, int i, int j, int w, int h);
      int r_lo, r_hi, c_lo, c_hi, n, s_red, s_grn, s_blu, ir, ic;
      bb3_pkg::out_beat_t o;
      r_lo = (r > 0) ? r - 1 : 0;
      r_hi = (r < h - 1) ? r + 1 : h - 1;
      c_lo = (c > 0) ? c - 1 : 0;
      c_hi = (c < w - 1) ? c + 1 : w - 1;
      n = 0;
      s_red = 0;
      s_grn = 0;
      s_blu = 0;
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          ir = i - 2 + k;
          ic = j - 2 + m;
          if (ir >= r_lo && ir <= r_hi && ic >= c_lo && ic <= c_hi) begin
            s_red += win[k*3+m].red;
            s_grn += win[k*3+m].green;
            s_blu += win[k*3+m].blue;
            n++;
          end
        end
      end
      if (n == 0) n = 1;
      o.out_red   = 8'((2 * s_red + n) / (2 * n));
      o.out_green = 8'((2 * s_grn + n) / (2 * n));
      o.out_blue  = 8'((2 * s_blu + n) / (2 * n));
      o.out_row   = bb3_pkg::ROW_W'(r);
      o.out_col   = bb3_pkg::COL_W'(c);
      o.run_last  = 1'b0;
      return o;
    endfunction

    function void take_pixel(bb3_pkg::in_beat_t p);
      int w, h, i, j;
      bb3_pkg::pix_t px, up2, up1;
      bit last_c, last_r;
      bb3_pkg::out_beat_t batch[$];
      w = frame_w();
      h = frame_h();
      i = row_pos;
      j = col_pos;
      px.red = p.in_red;
      px.green = p.in_green;
      px.blue = p.in_blue;
      up2 = older_line[j];
      up1 = newer_line[j];
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = px;
      older_line[j] = up1;
      newer_line[j] = px;
      last_c = (j == w - 1);
      last_r = (i == h - 1);
      if (i >= 1 && j >= 1) batch.push_back(blurred(i - 1, j - 1, i, j, w, h));
      if (i >= 1 && last_c) batch.push_back(blurred(i - 1, j, i, j, w, h));
      if (last_r && j >= 1) batch.push_back(blurred(i, j - 1, i, j, w, h));
      if (last_r && last_c) batch.push_back(blurred(i, j, i, j, w, h));
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[x]) blurred_due.push_back(batch[x]);
      if (last_c) begin
        col_pos = 0;
        row_pos = last_r ? 0 : i + 1;
      end else begin
        col_pos = j + 1;
      end
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void match_blurred(bb3_pkg::out_beat_t got);
      bb3_pkg::out_beat_t want;
      if (blurred_due.size() == 0) begin
        $error("blurred beat with nothing pending: row %0d col %0d",
               got.out_row, got.out_col);
        mismatches++;
        return;
      end
      want = blurred_due.pop_front();
      cmp("out_red", want.out_red, got.out_red);
      cmp("out_green", want.out_green, got.out_green);
      cmp("out_blue", want.out_blue, got.out_blue);
      cmp("out_row", want.out_row, got.out_row);
      cmp("out_col", want.out_col, got.out_col);
      cmp("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  bb3_pkg::in_beat_t              in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  bb3_pkg::out_beat_t             out_data_o;
  logic                           cfg_we_i = 1'b0;
  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  blur_checker chk;
  int idle_phase = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pix_sent = 0;

  box_blur_3x3_edge_adaptive_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int idle_pct(bit receiver);
    case (idle_phase)
      0:       return receiver ? 58 : 36;
      1:       return receiver ? 36 : 58;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bb3_pkg::in_beat_t mk_pixel(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
    bb3_pkg::in_beat_t p;
    p.in_red = r;
    p.in_green = g;
    p.in_blue = b;
    return p;
  endfunction

  function automatic bb3_pkg::in_beat_t rand_pixel();
    return mk_pixel(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.match_blurred(out_data_o);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  task automatic send_pixel(input bb3_pkg::in_beat_t px);
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chk.take_pixel(px);
    pix_sent++;
  endtask

  // drain: all blurred beats back, then let trailing row-0 pixels finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (chk.blurred_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic configure(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bb3_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    chk.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_frame(input logic [bb3_pkg::CFG_DATA_W-1:0] w_word,
                           input logic [bb3_pkg::CFG_DATA_W-1:0] h_word, input int npix);
    configure(bb3_pkg::REG_FRAME_WIDTH, w_word);
    configure(bb3_pkg::REG_FRAME_HEIGHT, h_word);
    repeat (npix) send_pixel(rand_pixel());
  endtask

  initial begin
    int base, w_eff, h_eff, npix;
    logic [bb3_pkg::CFG_DATA_W-1:0] w_word, h_word;
    chk = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size: row 0 only, nothing completes
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00));

    // 1x1 frame: each pixel blurs to itself
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'd1);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd1);
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'h80, 8'h7F, 8'h01));

    // zero sizes act as 1; upper width bits are dropped
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'h1800);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd0);
    send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF));
    send_pixel(mk_pixel(8'h01, 8'hFE, 8'h55));

    // single row, then wrap into the next frame
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'd3);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd1);
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'hFF, 8'h00, 8'h80));
    send_pixel(mk_pixel(8'h10, 8'h20, 8'h30));

    // single column
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'd1);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00));
    send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF));

    // full 3x3 frame with extreme red and green channels
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'd3);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
    for (int x = 0; x < 9; x++) begin
      send_pixel(mk_pixel((x % 2) ? 8'hFF : 8'h00, (x % 3 == 0) ? 8'hFF : 8'h00,
                          8'(x * 31)));
    end

    base = pix_sent;
    while (pix_sent - base < 400) begin
      idle_phase = (pix_sent - base < 135) ? 0 : (pix_sent - base < 270) ? 1 : 2;
      w_word = 13'($urandom_range(1, 8));
      h_word = 13'($urandom_range(1, 6));
      if ($urandom_range(0, 5) == 0) w_word[12:11] = 2'($urandom_range(1, 3));
      if ($urandom_range(0, 11) == 0) w_word[3:0] = 4'd0;
      if ($urandom_range(0, 11) == 0) h_word = '0;
      case ($urandom_range(0, 3))
        0: configure(bb3_pkg::REG_FRAME_WIDTH, w_word);
        1: configure(bb3_pkg::REG_FRAME_HEIGHT, h_word);
        default: begin
          configure(bb3_pkg::REG_FRAME_WIDTH, w_word);
          configure(bb3_pkg::REG_FRAME_HEIGHT, h_word);
        end
      endcase
      w_eff = chk.frame_w();
      h_eff = chk.frame_h();
      if ($urandom_range(0, 3) == 0) begin
        npix = $urandom_range(1, w_eff * h_eff + 3);
      end else begin
        npix = w_eff * h_eff * $urandom_range(1, 2);
      end
      repeat (npix) send_pixel(rand_pixel());
    end

    idle_phase = 2;
    // long receiver hold while pixels keep coming
    configure(bb3_pkg::REG_FRAME_WIDTH, 13'd8);
    configure(bb3_pkg::REG_FRAME_HEIGHT, 13'd6);
    hold_reqs++;
    repeat (48) send_pixel(rand_pixel());
    run_frame(13'd2047, 13'd1, 20);
    run_frame(13'd1, 13'd4096, 12);
    run_frame(13'd3, 13'h1FFF, 12);
    run_frame(13'd1024, 13'd3, 20);

    settle();
    if (chk.mismatches == 0 && chk.blurred_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: box_blur_3x3_edge_adaptive_top.f
+incdir+rtl/core
rtl/core/bb3_pkg.sv
rtl/core/bb3_linebuf.sv
rtl/core/bb3_window.sv
rtl/core/bb3_mean.sv
rtl/core/box_blur_3x3_edge_adaptive_top.sv
sim/tb_box_blur_3x3_edge_adaptive_top.sv
